@@ rtl/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VAL_W         = 8;
  localparam int OCC_W         = 5;

  typedef logic [VAL_W-1:0] val_t;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_SERVE  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t command;
    val_t item_value;
  } in_item_t;

  typedef struct packed {
    val_t             served_value;
    logic             served_valid;
    logic             dropped;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  // Broadcast from the queue control to every cell.
  typedef struct packed {
    logic do_insert;  // append or priority insert that is not dropped
    logic do_serve;   // serve on a non-empty queue
    logic by_value;   // insert position chosen by value compare
    val_t value;      // value being inserted
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/spq_cell.sv @@
// One slot of the queue: holds an entry and shifts it left or right.
// Depends on spq_pkg.
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire        clk,
  input  cell_ctrl_t ctrl,
  input  wire        occupied,    // slot index below the entry count
  input  wire        found_in,    // insert point lies in an earlier slot
  input  val_t       left_value,  // entry of the slot nearer the head
  input  val_t       right_value, // entry of the slot nearer the tail
  output logic       found_out,
  output val_t       value
);

  logic hit;
  val_t value_next;

  // First empty slot is the tail position; with by_value the first
  // strictly smaller entry wins, so equal values keep arrival order.
  assign hit       = !occupied || (ctrl.by_value && (value < ctrl.value));
  assign found_out = found_in || hit;

  always_comb begin
    value_next = value;
    if (ctrl.do_insert) begin
      if (found_in) begin
        value_next = left_value;
      end else if (hit) begin
        value_next = ctrl.value;
      end
    end else if (ctrl.do_serve) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

@@ rtl/sorted_priority_queue.sv @@
// Sorted priority queue: one transaction in, one result out per command.
// Latency: result is presented the cycle after the command is accepted.
// Throughput: one command per cycle while results are taken; a held result
// stalls input only when out_ready is low (single output register).
// Reset: entry count and output valid clear; entries stay undefined.
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire       clk,
  input  wire       rst,
  input  wire       in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  wire       out_ready,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             empty;
  logic             is_add;
  cell_ctrl_t       ctrl;
  out_item_t        result;

  val_t             cell_value [DEPTH];
  logic [DEPTH:0]   found;
  logic [DEPTH-1:0] occupied;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign is_add   = (in_data.command == CMD_APPEND) || (in_data.command == CMD_INSERT);

  assign ctrl.do_insert = accept && is_add && !full;
  assign ctrl.do_serve  = accept && (in_data.command == CMD_SERVE) && !empty;
  assign ctrl.by_value  = (in_data.command == CMD_INSERT);
  assign ctrl.value     = in_data.item_value;

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    val_t left_v;
    val_t right_v;

    assign occupied[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign left_v = in_data.item_value;
    end else begin : g_mid_l
      assign left_v = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_v = cell_value[i];
    end else begin : g_mid_r
      assign right_v = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occupied[i]),
      .found_in    (found[i]),
      .left_value  (left_v),
      .right_value (right_v),
      .found_out   (found[i+1]),
      .value       (cell_value[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.do_insert) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.do_serve) begin
      count_next = count - CNT_W'(1);
    end

    result              = '0;
    result.served_value = ctrl.do_serve ? cell_value[0] : '0;
    result.served_valid = ctrl.do_serve;
    result.dropped      = is_add && full;
    result.occupancy    = OCC_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

@@ rtl/spq_checker.sv @@
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
`default_nettype none

module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input wire       clk,
  input wire       rst,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input out_item_t out_data
);

  // Held result must not change while the consumer stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Input stalls only behind an undelivered result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free output slot");

  // A refused insert leaves the queue full.
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.dropped |->
      out_data.occupancy == OCC_W'(DEPTH) && !out_data.served_valid)
    else $error("drop reported on a non-full queue");

  // No served entry means a zero value.
  a_serve_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.served_valid |-> out_data.served_value == '0)
    else $error("value reported without a served entry");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

@@ verif/testbench.sv @@
// Testbench for sorted_priority_queue: directed table, then random command mix.
// Depends on spq_pkg and the sorted_priority_queue RTL; self-checking via an
// in-bench queue predictor.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int QUEUE_DEPTH   = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS  = 700;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int IDLE_PERCENT  = 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] code;
    val_t       value;
    int         reps;
    bit         typed;
    out_item_t  result;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // predictor state
  val_t      model_entries [QUEUE_DEPTH];
  int        model_count = 0;
  out_item_t expected_results [$];
  stim_row_t directed_plan [$];

  bit steady = 1'b0;  // no idling on either side while set
  int fail_count = 0;
  int cycle_count = 0;
  int n_commands = 0;
  int n_served = 0;
  int n_dropped = 0;
  int n_empty_serves = 0;
  int peak_occupancy = 0;

  sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  function automatic out_item_t result_of(val_t sv, logic svld, logic drop, int occ);
    out_item_t r;
    r.served_value = sv;
    r.served_valid = svld;
    r.dropped      = drop;
    r.occupancy    = OCC_W'(occ);
    return r;
  endfunction

  // Advance the queue predictor by one command and return its result.
  function automatic out_item_t queue_apply(logic [1:0] code, val_t v);
    out_item_t r;
    int pos;
    r = '0;
    case (code)
      CMD_APPEND, CMD_INSERT: begin
        if (model_count >= QUEUE_DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          pos = model_count;
          // first held entry strictly below v; equals stay ahead
          if (code == CMD_INSERT)
            for (int i = model_count - 1; i >= 0; i--)
              if (model_entries[i] < v) pos = i;
          for (int i = model_count; i > pos; i--)
            model_entries[i] = model_entries[i - 1];
          model_entries[pos] = v;
          model_count++;
        end
      end
      CMD_SERVE: begin
        if (model_count > 0) begin
          r.served_value = model_entries[0];
          r.served_valid = 1'b1;
          for (int i = 1; i < model_count; i++)
            model_entries[i - 1] = model_entries[i];
          model_count--;
        end
      end
      default: ;
    endcase
    r.occupancy = OCC_W'(model_count);
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_command(logic [1:0] code, val_t v, bit typed, out_item_t typed_result);
    in_item_t  item;
    out_item_t r;
    item.command    = cmd_t'(code);
    item.item_value = v;
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    r = queue_apply(code, v);
    expected_results.push_back(typed ? typed_result : r);
    n_commands++;
    if (r.served_valid) n_served++;
    if (r.dropped) n_dropped++;
    if (code == CMD_SERVE && !r.served_valid) n_empty_serves++;
    if (model_count > peak_occupancy) peak_occupancy = model_count;
    @(negedge clk);
  endtask

  task automatic add_row(logic [1:0] code, val_t v, int reps, bit typed, out_item_t r);
    stim_row_t row;
    row.code   = code;
    row.value  = v;
    row.reps   = reps;
    row.typed  = typed;
    row.result = r;
    directed_plan.push_back(row);
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no command pending: value %0d valid %0b dropped %0b occ %0d",
               out_data.served_value, out_data.served_valid, out_data.dropped,
               out_data.occupancy);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.served_value !== exp_r.served_value) begin
          $error("served_value: expected %0d, actual %0d",
                 exp_r.served_value, out_data.served_value);
          fail_count++;
        end
        if (out_data.served_valid !== exp_r.served_valid) begin
          $error("served_valid: expected %0b, actual %0b",
                 exp_r.served_valid, out_data.served_valid);
          fail_count++;
        end
        if (out_data.dropped !== exp_r.dropped) begin
          $error("dropped: expected %0b, actual %0b", exp_r.dropped, out_data.dropped);
          fail_count++;
        end
        if (out_data.occupancy !== exp_r.occupancy) begin
          $error("occupancy: expected %0d, actual %0d",
                 exp_r.occupancy, out_data.occupancy);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk)
    out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);

  initial begin
    int counted;
    int mode;
    int roll;
    logic [1:0] code;
    val_t v;
    stim_row_t row;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table; typed results only where obvious
    add_row(CMD_SERVE,  8'h00, 1, 1'b1, result_of(8'h00, 1'b0, 1'b0, 0));
    add_row(CMD_UNUSED, 8'hFF, 1, 1'b1, result_of(8'h00, 1'b0, 1'b0, 0));
    add_row(CMD_INSERT, 8'h3C, 1, 1'b1, result_of(8'h00, 1'b0, 1'b0, 1));
    add_row(CMD_SERVE,  8'h00, 1, 1'b1, result_of(8'h3C, 1'b1, 1'b0, 0));
    add_row(CMD_APPEND, 8'hFF, 1, 1'b1, result_of(8'h00, 1'b0, 1'b0, 1));
    add_row(CMD_APPEND, 8'h00, 1, 1'b1, result_of(8'h00, 1'b0, 1'b0, 2));
    add_row(CMD_INSERT, 8'h80, 1, 1'b0, '0);
    add_row(CMD_INSERT, 8'h80, 1, 1'b0, '0);
    add_row(CMD_INSERT, 8'h00, 1, 1'b0, '0);
    add_row(CMD_INSERT, 8'hFF, 1, 1'b0, '0);
    add_row(CMD_INSERT, 8'h7F, 1, 1'b0, '0);
    add_row(CMD_INSERT, 8'hAA, 9, 1'b0, '0);
    add_row(CMD_APPEND, 8'h11, 1, 1'b1, result_of(8'h00, 1'b0, 1'b1, 16));
    add_row(CMD_INSERT, 8'hFF, 1, 1'b1, result_of(8'h00, 1'b0, 1'b1, 16));
    add_row(CMD_UNUSED, 8'h55, 1, 1'b1, result_of(8'h00, 1'b0, 1'b0, 16));
    add_row(CMD_SERVE,  8'h00, 1, 1'b1, result_of(8'hFF, 1'b1, 1'b0, 15));
    add_row(CMD_SERVE,  8'h00, 15, 1'b0, '0);
    add_row(CMD_SERVE,  8'h00, 1, 1'b1, result_of(8'h00, 1'b0, 1'b0, 0));

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      repeat (row.reps) send_command(row.code, row.value, row.typed, row.result);
    end

    // random part: fill-heavy, drain-heavy and balanced stretches
    counted = 0;
    mode = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 40 == 0) mode = $urandom_range(2);
      steady = (counted >= 250 && counted < 400);
      roll = $urandom_range(99);
      if (roll < 2)
        code = CMD_UNUSED;
      else if (roll < (mode == 0 ? 80 : (mode == 1 ? 25 : 52)))
        code = ($urandom_range(99) < 60) ? CMD_INSERT : CMD_APPEND;
      else
        code = CMD_SERVE;
      case ($urandom_range(3))
        0: v = ($urandom_range(1) != 0) ? 8'h00 + val_t'($urandom_range(1))
                                        : 8'hFE + val_t'($urandom_range(1));
        1: v = 8'h40 + val_t'($urandom_range(3));  // many equal values
        default: v = val_t'($urandom);
      endcase
      send_command(code, v, 1'b0, '0);
      if (code != CMD_UNUSED) counted++;
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands: %0d serves returned a value, %0d on an empty queue,",
             n_commands, n_served, n_empty_serves);
    $display("%0d appends/inserts dropped when full, peak occupancy %0d.",
             n_dropped, peak_occupancy);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
verif/testbench.sv
